>>> hw/rtl/i2da_pkg.sv
`timescale 1ns / 1ps

package i2da_pkg;

  localparam int unsigned InW        = 16;
  localparam int unsigned MagW       = 16;
  localparam int unsigned DigitW     = 4;
  localparam int unsigned NumDigits  = 5;
  localparam int unsigned CountW     = 3;
  localparam int unsigned ProdW      = 32;
  localparam int unsigned RecipShift = 19;

  localparam logic [MagW-1:0] Recip     = 16'hCCCD;
  localparam logic [MagW-1:0] Radix     = 16'd10;
  localparam logic [7:0]      CharMinus = 8'd45;
  localparam logic [7:0]      CharZero  = 8'd48;

  typedef struct packed {
    logic                               neg;
    logic [MagW-1:0]                    mag;
    logic [NumDigits-1:0][DigitW-1:0]   digits;
    logic [CountW-1:0]                  ndig;
  } pipe_t;

endpackage

>>> hw/rtl/i2da_abs_stage.sv
`timescale 1ns / 1ps

module i2da_abs_stage (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [i2da_pkg::InW-1:0] in_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output i2da_pkg::pipe_t               out_data
);

  logic            valid;
  i2da_pkg::pipe_t data;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data.neg    <= in_value[i2da_pkg::InW-1];
      data.mag    <= in_value[i2da_pkg::InW-1] ? (i2da_pkg::MagW'(0) - i2da_pkg::MagW'(in_value))
                                               : i2da_pkg::MagW'(in_value);
      data.digits <= '0;
      data.ndig   <= i2da_pkg::CountW'(1);
    end
  end

endmodule

>>> hw/rtl/i2da_digit_stage.sv
`timescale 1ns / 1ps

module i2da_digit_stage #(
  parameter int unsigned Index = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  i2da_pkg::pipe_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output i2da_pkg::pipe_t out_data
);

  logic                        valid;
  i2da_pkg::pipe_t             data;
  i2da_pkg::pipe_t             data_next;
  logic [i2da_pkg::ProdW-1:0]  prod;
  logic [i2da_pkg::MagW-1:0]   quot;
  logic [i2da_pkg::MagW-1:0]   rem;
  logic [i2da_pkg::ProdW-1:0]  quot_x10;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_comb begin
    prod     = i2da_pkg::ProdW'(in_data.mag) * i2da_pkg::ProdW'(i2da_pkg::Recip);
    quot     = i2da_pkg::MagW'(prod >> i2da_pkg::RecipShift);
    quot_x10 = i2da_pkg::ProdW'(quot) * i2da_pkg::ProdW'(i2da_pkg::Radix);
    rem      = in_data.mag - i2da_pkg::MagW'(quot_x10);

    data_next               = in_data;
    data_next.mag           = quot;
    data_next.digits[Index] = rem[i2da_pkg::DigitW-1:0];
    if (in_data.mag != '0) begin
      data_next.ndig = i2da_pkg::CountW'(Index + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

endmodule

>>> hw/rtl/i2da_serializer.sv
`timescale 1ns / 1ps

module i2da_serializer (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  i2da_pkg::pipe_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_char,
  output logic            out_last
);

  logic                                               busy;
  logic                                               neg_pend;
  logic [i2da_pkg::CountW-1:0]                        pos;
  logic [i2da_pkg::NumDigits-1:0][i2da_pkg::DigitW-1:0] digits;

  assign out_valid = busy;
  assign out_last  = !neg_pend && (pos == '0);
  assign out_char  = neg_pend ? i2da_pkg::CharMinus
                              : i2da_pkg::CharZero + 8'(digits[pos]);
  assign in_ready  = !busy || (out_ready && out_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      neg_pend <= 1'b0;
      pos      <= '0;
    end else if (in_valid && in_ready) begin
      busy     <= 1'b1;
      neg_pend <= in_data.neg;
      pos      <= in_data.ndig - i2da_pkg::CountW'(1);
    end else if (busy && out_ready) begin
      if (neg_pend) begin
        neg_pend <= 1'b0;
      end else if (pos == '0) begin
        busy <= 1'b0;
      end else begin
        pos <= pos - i2da_pkg::CountW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      digits <= in_data.digits;
    end
  end

endmodule

>>> hw/rtl/int16_to_decimal_ascii_core.sv
// A number passes through one magnitude stage, five divide-by-ten stages and one
// serializer load before its first character is shown.
// Throughput: one character per cycle on the output port while out_ready is high; a
// number is 1 to 6 characters; the stages take a number per cycle until they fill.
// Reset: synchronous rst clears all valid bits and the serializer's busy, sign and position state.
`timescale 1ns / 1ps

module int16_to_decimal_ascii_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [i2da_pkg::InW-1:0]   value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        char_code,
  output logic                              last
);

  localparam int unsigned N = i2da_pkg::NumDigits;

  logic            stg_valid [N+1];
  logic            stg_ready [N+1];
  i2da_pkg::pipe_t stg_data  [N+1];

  i2da_abs_stage u_abs (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_value  (value),
    .out_valid (stg_valid[0]),
    .out_ready (stg_ready[0]),
    .out_data  (stg_data[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_digit
    i2da_digit_stage #(
      .Index (i)
    ) u_digit (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stg_valid[i]),
      .in_ready  (stg_ready[i]),
      .in_data   (stg_data[i]),
      .out_valid (stg_valid[i+1]),
      .out_ready (stg_ready[i+1]),
      .out_data  (stg_data[i+1])
    );
  end

  i2da_serializer u_ser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (stg_valid[N]),
    .in_ready  (stg_ready[N]),
    .in_data   (stg_data[N]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (char_code),
    .out_last  (last)
  );

endmodule
